### hdl/hotp_code_generator_top_defines.svh
// Assertion macros shared by the HOTP generator modules.
`ifndef HOTP_CODE_GENERATOR_TOP_DEFINES_SVH
`define HOTP_CODE_GENERATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define HOTP_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define HOTP_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### hdl/hotp_pkg.sv
// Shared types and constants for the HOTP generator.
`timescale 1ns / 1ps
package hotp_pkg;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] TRUNC_MASK = 32'h7FFFFFFF;
    localparam logic [31:0] CODE_MODULUS = 32'd1000000;
    // 2^20 mod 1000000, used to fold the upper bits back into the low 20
    localparam logic [15:0] FOLD_RESIDUE = 16'd48576;
    localparam logic [1:0] REG_KEY_FIRST = 2'd0;
    localparam logic [1:0] REG_KEY_SECOND = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_TRUNC, ST_MOD, ST_OUT
    } state_t;

    // Control from sequencer to round unit
    typedef struct packed {
        logic       init;   // load working vars from chain value
        logic       load_w; // load message block into schedule
        logic       round;  // run one round
        logic       add;    // fold working vars into chain value
        logic       reset_h;// chain value to initial vector
        logic [6:0] rnd;
    } sha_ctrl_t;
endpackage

### hdl/hotp_sha1_round.sv
// SHA-1 round unit: one round per cycle with a 16-word rolling schedule.
`timescale 1ns / 1ps
`include "hotp_code_generator_top_defines.svh"
module hotp_sha1_round
(
    input  logic               clk,
    input  logic               rst_n,
    input  hotp_pkg::sha_ctrl_t ctrl,
    input  logic [511:0]       block,
    output logic [159:0]       digest
);
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h_reg [5];
    logic [31:0] f, k, t, wn, wcur;

    always_comb
    begin
        wcur = w_reg[0];
        wn = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wn = {wn[30:0], wn[31]};
        if (ctrl.rnd < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (ctrl.rnd < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (ctrl.rnd < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wcur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= '0;
            end
        end
        else if (ctrl.reset_h)
        begin
            h_reg[0] <= hotp_pkg::H0;
            h_reg[1] <= hotp_pkg::H1;
            h_reg[2] <= hotp_pkg::H2;
            h_reg[3] <= hotp_pkg::H3;
            h_reg[4] <= hotp_pkg::H4;
        end
        else if (ctrl.add)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_w)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32 * i -: 32];
            end
        end
        else if (ctrl.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wn;
        end
        // Start from the initial vector when the chain is being restarted
        if (ctrl.init)
        begin
            a_reg <= ctrl.reset_h ? hotp_pkg::H0 : h_reg[0];
            b_reg <= ctrl.reset_h ? hotp_pkg::H1 : h_reg[1];
            c_reg <= ctrl.reset_h ? hotp_pkg::H2 : h_reg[2];
            d_reg <= ctrl.reset_h ? hotp_pkg::H3 : h_reg[3];
            e_reg <= ctrl.reset_h ? hotp_pkg::H4 : h_reg[4];
        end
        else if (ctrl.round)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
        end
    end

    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

    `HOTP_ASSERT_IMP(a_excl, clk, rst_n, ctrl.round, !ctrl.add && !ctrl.init, "round overlaps")
    `HOTP_ASSERT_IMP(a_rnd, clk, rst_n, ctrl.round, ctrl.rnd < 7'd80, "round index high")
    `HOTP_ASSERT_IMP(a_load, clk, rst_n, ctrl.load_w, !ctrl.round, "load during round")
endmodule

### hdl/hotp_trunc_mod.sv
// Reduction of a 31-bit value modulo 1000000: three 2^20 folds, then one subtract.
`timescale 1ns / 1ps
`include "hotp_code_generator_top_defines.svh"
module hotp_trunc_mod
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] value,
    output logic        done,
    output logic [19:0] rem
);
    logic [30:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic [26:0] fold_prod;
    logic [30:0] fold_sum;
    logic [31:0] diff;

    always_comb
    begin
        fold_prod = 27'(acc_reg[30:20]) * 27'(hotp_pkg::FOLD_RESIDUE);
        fold_sum = {4'b0, fold_prod} + {11'b0, acc_reg[19:0]};
        diff = {1'b0, acc_reg} - hotp_pkg::CODE_MODULUS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Fold on steps 0 to 2, leaving the value below twice the modulus; subtract once on step 3
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= value;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 2'd3)
            begin
                acc_reg <= diff[31] ? acc_reg : diff[30:0];
            end
            else
            begin
                acc_reg <= fold_sum;
            end
        end
    end

    assign done = busy_reg && (cnt_reg == 2'd3);
    assign rem = acc_reg[19:0];

    `HOTP_ASSERT_NXT(a_rem, clk, rst_n, done, acc_reg < hotp_pkg::CODE_MODULUS[30:0],
        "remainder out of range")
    `HOTP_ASSERT_IMP(a_near, clk, rst_n, done, acc_reg < (hotp_pkg::CODE_MODULUS[30:0] << 1),
        "folded value too large")
    `HOTP_ASSERT_IMP(a_start, clk, rst_n, start, !busy_reg, "start while busy")
endmodule

### hdl/hotp_code_generator_top.sv
// HOTP generator: sequencer, key padding, truncation and output register.
// Usage:
//   Write key_bytes_first (index 0), key_bytes_second (1) and key_length (2)
//   over the config channel (cfg_valid/cfg_ready, always ready) while idle.
//   Present moving_factor with in_valid; it is accepted when in_stall is low.
//   in_stall stays high from acceptance until the code has been taken.
//   Four SHA-1 compressions run through one round unit, each as load with
//   init, 80 rounds and fold; then a truncation step and the modulo
//   reduction (three folds, one subtract, one capture) produce the code.
//   One request is processed at a time.
//   The code is held on code with out_valid until out_stall is low.
//   Reset clears the key words, sets key_length to 10 and drops any request.
//   A stalled result holds; no new request is taken until it leaves.
`timescale 1ns / 1ps
`include "hotp_code_generator_top_defines.svh"
module hotp_code_generator_top #(
    parameter int KEY_MAX_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] moving_factor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [19:0] code
);
    localparam int KB = (KEY_MAX_BYTES < 16) ? KEY_MAX_BYTES : 16;

    hotp_pkg::state_t state_reg, state_next;
    logic [63:0]  key_first_reg, key_second_reg, mf_reg;
    logic [127:0] key_all;
    logic [4:0]   key_len_reg;
    logic [6:0]   rnd_reg, rnd_next;
    logic [1:0]   blk_reg, blk_next;
    logic [2:0]   mcnt_reg, mcnt_next;
    logic [159:0] inner_reg, digest;
    logic [511:0] block, kblk;
    logic [19:0]  code_reg;
    logic [4:0]   len_eff;
    logic [7:0]   dbytes [20];
    logic [3:0]   off;
    logic [31:0]  word;
    logic [19:0]  rem;
    logic         mod_start, mod_done;
    hotp_pkg::sha_ctrl_t ctrl;

    assign cfg_ready = 1'b1;
    assign key_all = {key_first_reg, key_second_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_first_reg <= '0;
            key_second_reg <= '0;
            key_len_reg <= 5'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hotp_pkg::REG_KEY_FIRST:  key_first_reg <= cfg_data;
                hotp_pkg::REG_KEY_SECOND: key_second_reg <= cfg_data;
                hotp_pkg::REG_KEY_LENGTH: key_len_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Block chosen by block number: key xor pad for blocks 0 and 2, padded factor or inner hash for 1 and 3
    always_comb
    begin
        len_eff = (key_len_reg > 5'(KB)) ? 5'(KB) : key_len_reg;
        kblk = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < len_eff)
            begin
                kblk[511 - 8 * i -: 8] = key_all[127 - 8 * i -: 8];
            end
        end
        case (blk_reg)
            2'd0: block = kblk ^ {64{8'h36}};
            2'd1: block = {mf_reg, 8'h80, 376'd0, 64'd576};
            2'd2: block = kblk ^ {64{8'h5C}};
            default: block = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 20; i++)
        begin
            dbytes[i] = digest[159 - 8 * i -: 8];
        end
        off = dbytes[19][3:0];
        word = {dbytes[5'(off)], dbytes[5'(off) + 5'd1], dbytes[5'(off) + 5'd2],
                dbytes[5'(off) + 5'd3]} & hotp_pkg::TRUNC_MASK;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        blk_next = blk_reg;
        mcnt_next = mcnt_reg;
        case (state_reg)
            hotp_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = hotp_pkg::ST_LOAD;
                    blk_next = 2'd0;
                end
            hotp_pkg::ST_LOAD:
            begin
                state_next = hotp_pkg::ST_ROUND;
                rnd_next = '0;
            end
            hotp_pkg::ST_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    state_next = hotp_pkg::ST_ADD;
                end
            end
            hotp_pkg::ST_ADD:
            begin
                blk_next = blk_reg + 2'd1;
                state_next = (blk_reg == 2'd3) ? hotp_pkg::ST_TRUNC : hotp_pkg::ST_LOAD;
            end
            hotp_pkg::ST_TRUNC:
            begin
                state_next = hotp_pkg::ST_MOD;
                mcnt_next = '0;
            end
            hotp_pkg::ST_MOD:
            begin
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd4)
                begin
                    state_next = hotp_pkg::ST_OUT;
                end
            end
            hotp_pkg::ST_OUT:
                if (!out_stall)
                begin
                    state_next = hotp_pkg::ST_IDLE;
                end
            default: state_next = hotp_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl = '0;
        ctrl.rnd = rnd_reg;
        mod_start = 1'b0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            hotp_pkg::ST_IDLE:  in_stall = 1'b0;
            hotp_pkg::ST_LOAD:
            begin
                ctrl.load_w = 1'b1;
                ctrl.init = 1'b1;
                ctrl.reset_h = (blk_reg == 2'd0) || (blk_reg == 2'd2);
            end
            hotp_pkg::ST_ROUND: ctrl.round = 1'b1;
            hotp_pkg::ST_ADD:   ctrl.add = 1'b1;
            hotp_pkg::ST_TRUNC: mod_start = 1'b1;
            hotp_pkg::ST_MOD:   ;
            hotp_pkg::ST_OUT:   out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hotp_pkg::ST_IDLE;
            rnd_reg <= '0;
            blk_reg <= '0;
            mcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            blk_reg <= blk_next;
            mcnt_reg <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hotp_pkg::ST_IDLE && in_valid)
        begin
            mf_reg <= moving_factor;
        end
        // Inner hash is complete once the second block has been folded in
        if (state_reg == hotp_pkg::ST_LOAD && blk_reg == 2'd2)
        begin
            inner_reg <= digest;
        end
        if (state_reg == hotp_pkg::ST_MOD && mcnt_reg == 3'd4)
        begin
            code_reg <= rem;
        end
    end

    hotp_sha1_round u_round
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .block  (block),
        .digest (digest)
    );

    hotp_trunc_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (word[30:0]),
        .done  (mod_done),
        .rem   (rem)
    );

    assign code = code_reg;

    `HOTP_ASSERT_IMP(a_stall, clk, rst_n, out_valid, in_stall, "accepting while result waits")
    `HOTP_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(code),
        "stalled code moved")
    `HOTP_ASSERT_IMP(a_mod, clk, rst_n, mod_done,
        state_reg == hotp_pkg::ST_MOD && mcnt_reg == 3'd3, "modulo finished out of step")
endmodule

### tb/hotp_code_generator_checker.sv
// Checker for the HOTP generator: tracks the key, predicts each code and compares.
`timescale 1ns / 1ps
module hotp_code_generator_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] moving_factor,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [19:0] code,
    output int          errors,
    output int          pending
);
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [4:0]  key_len;
    logic [19:0] code_queue[$];

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] sha1_compress(logic [159:0] hv, logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (i = 16; i < 80; i++)
            w[i] = rol(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
        {a, b, c, d, e} = hv;
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
    endfunction

    function automatic logic [19:0] hotp_code(logic [63:0] k1, logic [63:0] k2,
                                              logic [4:0] len, logic [63:0] mf);
        logic [127:0] key_all;
        logic [511:0] key_blk;
        logic [159:0] iv;
        logic [159:0] inner;
        logic [159:0] digest;
        logic [31:0]  word;
        int n, i, off;
        key_all = {k1, k2};
        key_blk = '0;
        n = (len > 16) ? 16 : len;
        for (i = 0; i < n; i++)
            key_blk[511 - 8 * i -: 8] = key_all[127 - 8 * i -: 8];
        iv = {hotp_pkg::H0, hotp_pkg::H1, hotp_pkg::H2, hotp_pkg::H3, hotp_pkg::H4};
        inner = sha1_compress(iv, key_blk ^ {64{8'h36}});
        inner = sha1_compress(inner, {mf, 8'h80, 408'b0, 32'd576});
        digest = sha1_compress(iv, key_blk ^ {64{8'h5C}});
        digest = sha1_compress(digest, {inner, 8'h80, 312'b0, 32'd672});
        off = digest[3:0];
        word = digest[159 - 8 * off -: 32] & hotp_pkg::TRUNC_MASK;
        return 20'(word % hotp_pkg::CODE_MODULUS);
    endfunction

    assign pending = code_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [19:0] want;
        if (!rst_n)
        begin
            key_hi <= '0;
            key_lo <= '0;
            key_len <= 5'd10;
            errors <= 0;
            code_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hotp_pkg::REG_KEY_FIRST:  key_hi <= cfg_data;
                    hotp_pkg::REG_KEY_SECOND: key_lo <= cfg_data;
                    hotp_pkg::REG_KEY_LENGTH: key_len <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                code_queue.push_back(hotp_code(key_hi, key_lo, key_len, moving_factor));
            if (out_valid && !out_stall)
            begin
                if (code_queue.size() == 0)
                begin
                    $display("%0t: unexpected code, actual %0d", $time, code);
                    errors <= errors + 1;
                end
                else
                begin
                    want = code_queue.pop_front();
                    if (want !== code)
                    begin
                        $display("%0t: code mismatch, expected %0d, actual %0d",
                                 $time, want, code);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/hotp_code_generator_top_test.sv
// Testbench top for the HOTP generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module hotp_code_generator_top_test;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] moving_factor = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [19:0] code;
    int          errors;
    int          pending;
    int          burst_left = 1;
    int          stall_mode = 0;
    int          stall_left = 0;

    hotp_code_generator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .moving_factor(moving_factor),
        .out_valid(out_valid), .out_stall(out_stall), .code(code)
    );

    hotp_code_generator_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .moving_factor(moving_factor),
        .out_valid(out_valid), .out_stall(out_stall), .code(code),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: alternate between free-flowing stretches and random stalling.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 800);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 3) == 0);
            default: out_stall = ($urandom_range(0, 1) == 0);
        endcase
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_key(logic [63:0] k1, logic [63:0] k2, logic [4:0] len);
        write_reg(hotp_pkg::REG_KEY_FIRST, k1);
        write_reg(hotp_pkg::REG_KEY_SECOND, k2);
        write_reg(hotp_pkg::REG_KEY_LENGTH, {59'b0, len});
    endtask

    task automatic send_factor(logic [63:0] mf);
        int gap;
        moving_factor = mf;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 500) : $urandom_range(0, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // Hold off until every predicted code has come back.
    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    function automatic logic [63:0] rand_factor();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 100000));
            1: return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int p, i;
        logic [4:0] len;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset key, then factor extremes and a short counter run.
        send_factor(64'h0);
        send_factor(64'hFFFF_FFFF_FFFF_FFFF);
        send_factor(64'h8000_0000_0000_0000);
        send_factor(64'h5555_5555_5555_5555);
        send_factor(64'hAAAA_AAAA_AAAA_AAAA);
        for (i = 1; i < 8; i++)
            send_factor(64'(i));
        drain();
        set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
        send_factor(64'h0);
        send_factor(64'hFFFF_FFFF_FFFF_FFFF);
        drain();
        // Length beyond the limit, and an empty key.
        write_reg(hotp_pkg::REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_factor(64'h1);
        drain();
        write_reg(hotp_pkg::REG_KEY_LENGTH, 64'd17);
        send_factor(64'h1);
        drain();
        write_reg(hotp_pkg::REG_KEY_LENGTH, 64'd0);
        send_factor(64'h1);
        drain();
        // Write to the unused index (the design ignores it), then load a one-byte key.
        write_reg(2'd3, 64'hDEAD_BEEF_0123_4567);
        set_key(64'h3132_3334_3536_3738, 64'h0, 5'd1);
        send_factor(64'h1);
        send_factor(64'h2);
        drain();

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: len = 5'd16;
                1: len = 5'd1;
                2: len = 5'd0;
                3: len = 5'd31;
                default: len = 5'($urandom_range(0, 31));
            endcase
            set_key({$urandom, $urandom}, {$urandom, $urandom}, len);
            for (i = 0; i < 220; i++)
                send_factor(rand_factor());
            drain();
        end

        repeat (400) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/hotp_pkg.sv
hdl/hotp_sha1_round.sv
hdl/hotp_trunc_mod.sv
hdl/hotp_code_generator_top.sv
tb/hotp_code_generator_checker.sv
tb/hotp_code_generator_top_test.sv
